### src/tmcw_pkg.sv
`default_nettype none

package tmcw_pkg;

  localparam int unsigned COLUMNS_DEF     = 80;
  localparam int unsigned SCROLL_ROWS_DEF = 24;
  localparam int unsigned SCREEN_ROWS_DEF = 25;

  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_BS      = 8'h08;

  typedef enum logic [1:0] {
    CMD_PRINT     = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_LEFT      = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BS2,
    ST_BS3,
    ST_READ,
    ST_COPY,
    ST_CLEAR
  } state_e;

endpackage

`default_nettype wire

### src/tmcw_ram.sv
`default_nettype none

module tmcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### src/text_mode_console_writer.sv
// Print and left arrow give one result the cycle after start, backspace three results from
//   there, a cell read one result after the RAM read and the result register. One command
//   a cycle for print and left arrow, unless a print scrolls; a read or backspace holds busy.
// A print that reaches the scroll row holds busy while rows are copied up and the last
//   scroll row cleared. Receiver cannot stall.
// Reset: async, active low; screen RAM then cleared one cell a cycle, busy until all are cleared.
`default_nettype none

module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int unsigned COLUMNS     = COLUMNS_DEF,
  parameter int unsigned SCROLL_ROWS = SCROLL_ROWS_DEF,
  parameter int unsigned SCREEN_ROWS = SCREEN_ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command transaction
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_index_i,
  // attribute register
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // result transaction, one cycle each, no back-pressure
  output logic             result_strobe_o,
  output logic             uart_valid_o,
  output logic [7:0]       uart_byte_o,
  output logic [15:0]      cell_value_o,
  output logic [10:0]      cursor_pos_o,
  output logic             last_o
);

  // Geometry. The scroll region ends at row SCROLL_ROWS, or one row short of the
  // screen when SCROLL_ROWS is not below SCREEN_ROWS.
  localparam int unsigned CELLS        = COLUMNS * SCREEN_ROWS;
  localparam int unsigned SCROLL_CELLS = (SCROLL_ROWS < SCREEN_ROWS) ?
                                         SCROLL_ROWS * COLUMNS :
                                         (SCREEN_ROWS - 1) * COLUMNS;
  localparam int unsigned COPY_CELLS   = SCROLL_CELLS - COLUMNS;
  localparam int unsigned CellW        = $clog2(CELLS + 1);
  localparam int unsigned AddrW        = $clog2(CELLS);
  localparam int unsigned ColW         = $clog2(COLUMNS);

  state_e            state_q, state_d;
  logic [CellW-1:0]  cursor_q, cursor_d;   // row*COLUMNS + column
  logic [ColW-1:0]   col_q, col_d;         // column of the cursor, spares a modulo
  logic [CellW-1:0]  cnt_q, cnt_d;         // sweep counter for init, copy and clear
  logic [7:0]        attr_q;

  logic              strobe_q, strobe_d;
  logic              uvalid_q, uvalid_d;
  logic [7:0]        ubyte_q, ubyte_d;
  logic [15:0]       cell_q, cell_d;
  logic              last_q, last_d;
  logic              rd_ok_q, rd_ok_d;     // read address within the screen

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  logic              accept;
  logic [CellW-1:0]  cur_print;
  logic              scroll_hit;
  logic              cur_nonzero;
  logic [CellW-1:0]  cur_back;
  logic [ColW-1:0]   col_back;
  logic [ColW-1:0]   col_fwd;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Cursor arithmetic for the command at the port.
  assign col_fwd     = (col_q == ColW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
  assign cur_print   = (char_code_i == CHAR_NEWLINE) ?
                       cursor_q + (CellW'(COLUMNS) - CellW'(col_q)) :
                       cursor_q + 1'b1;
  // Cursor only ever steps onto the scroll boundary, never past it.
  assign scroll_hit  = (cur_print == CellW'(SCROLL_CELLS));
  assign cur_nonzero = (cursor_q != '0);
  assign cur_back    = cur_nonzero ? cursor_q - 1'b1 : cursor_q;
  assign col_back    = !cur_nonzero ? col_q :
                       (col_q == '0) ? ColW'(COLUMNS - 1) : col_q - 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (cnt_q == CellW'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CMD_PRINT:     state_d = scroll_hit ? ST_COPY : ST_IDLE;
            CMD_BACKSPACE: state_d = ST_BS2;
            CMD_LEFT:      state_d = ST_IDLE;
            CMD_READ:      state_d = ST_READ;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_BS2:  state_d = ST_BS3;
      ST_BS3:  state_d = ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      ST_COPY: begin
        if (cnt_q == CellW'(COPY_CELLS)) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (cnt_q == CellW'(SCROLL_CELLS - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and results
  always_comb begin
    cursor_d  = cursor_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    strobe_d  = 1'b0;
    uvalid_d  = 1'b0;
    ubyte_d   = '0;
    cell_d    = '0;
    last_d    = 1'b0;
    rd_ok_d   = rd_ok_q;
    ram_we    = 1'b0;
    ram_waddr = cursor_q[AddrW-1:0];
    ram_wdata = '0;
    ram_raddr = AddrW'(cell_index_i);

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AddrW-1:0];
        cnt_d     = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CMD_PRINT: begin
              strobe_d = 1'b1;
              uvalid_d = 1'b1;
              ubyte_d  = char_code_i;
              last_d   = 1'b1;
              if (char_code_i != CHAR_NEWLINE) begin
                ram_we    = 1'b1;
                ram_wdata = {attr_q, char_code_i};
                col_d     = col_fwd;
              end else begin
                col_d     = '0;
              end
              cursor_d = scroll_hit ? CellW'(COPY_CELLS) : cur_print;
              cnt_d    = '0;
            end
            CMD_BACKSPACE: begin
              strobe_d  = 1'b1;
              uvalid_d  = 1'b1;
              ubyte_d   = CHAR_BS;
              cursor_d  = cur_back;
              col_d     = col_back;
              ram_we    = 1'b1;
              ram_waddr = cur_back[AddrW-1:0];
              ram_wdata = {attr_q, CHAR_SPACE};
            end
            CMD_LEFT: begin
              strobe_d = 1'b1;
              uvalid_d = 1'b1;
              ubyte_d  = CHAR_BS;
              last_d   = 1'b1;
              cursor_d = cur_back;
              col_d    = col_back;
            end
            CMD_READ: begin
              rd_ok_d = (32'(cell_index_i) < 32'(CELLS));
            end
            default: ;
          endcase
        end
      end
      ST_BS2: begin
        strobe_d = 1'b1;
        uvalid_d = 1'b1;
        ubyte_d  = CHAR_SPACE;
      end
      ST_BS3: begin
        strobe_d = 1'b1;
        uvalid_d = 1'b1;
        ubyte_d  = CHAR_BS;
        last_d   = 1'b1;
      end
      ST_READ: begin
        strobe_d = 1'b1;
        cell_d   = rd_ok_q ? ram_rdata : '0;
        last_d   = 1'b1;
      end
      ST_COPY: begin
        // read one row ahead, write back what was read last cycle
        ram_raddr = AddrW'(cnt_q + CellW'(COLUMNS));
        ram_we    = (cnt_q != '0);
        ram_waddr = AddrW'(cnt_q - 1'b1);
        ram_wdata = ram_rdata;
        if (cnt_q != CellW'(COPY_CELLS)) cnt_d = cnt_q + 1'b1;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AddrW-1:0];
        cnt_d     = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cursor_q <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
      attr_q   <= ATTR_RESET;
      strobe_q <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
      rd_ok_q  <= rd_ok_d;
      if (cfg_we_i) attr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    uvalid_q <= uvalid_d;
    ubyte_q  <= ubyte_d;
    cell_q   <= cell_d;
    last_q   <= last_d;
  end

  tmcw_ram #(
    .Width (16),
    .Depth (CELLS)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_strobe_o = strobe_q;
  assign uart_valid_o    = uvalid_q;
  assign uart_byte_o     = ubyte_q;
  assign cell_value_o    = cell_q;
  assign cursor_pos_o    = 11'(cursor_q);
  assign last_o          = last_q;

  // Only the backspace echo has results that are not final.
  a_not_last_is_bs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !last_q) |-> (state_q == ST_BS2 || state_q == ST_BS3))
    else $error("non-final result outside backspace echo");

  // Cursor always stays inside the scroll region once a command has settled.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q < CellW'(SCROLL_CELLS)))
    else $error("cursor beyond scroll region");

  // An idle block with no transaction leaves the screen untouched.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !start_i) |-> !ram_we)
    else $error("screen write while idle");

  // A cell read gives a final result, with no UART byte, once ST_READ has passed.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_READ) |=> ##1 (strobe_q && last_q && !uvalid_q))
    else $error("cell read result missing");

endmodule

`default_nettype wire
